@@ hdl/egpc_pkg.sv @@
// ----------------------------------------------------------------------------
// egpc_pkg
// Shared types, codes and helper functions of the echo gate with playout clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package egpc_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_FAR   = 2'd0,
        KIND_MIC   = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_MS   = 3'd4;

    // register reset values
    localparam logic [14:0]        RST_MAKEUP_GAIN    = 15'd256;
    localparam logic signed [9:0]  RST_GATE_FACTOR    = 10'sd0;
    localparam logic [15:0]        RST_LOUD_THRESHOLD = 16'd256;
    localparam logic [15:0]        RST_HANGOVER_MS    = 16'd200;
    localparam logic [7:0]         RST_BYTES_PER_MS   = 8'd32;

    localparam int DEFAULT_MAX_FRAME_SAMPLES = 1024;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
    localparam logic signed [31:0] SAT_HI     = 32'sd32767;
    localparam logic signed [31:0] SAT_LO     = -32'sd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREP,
        ST_DIV,
        ST_COMMIT,
        ST_HOLD,
        ST_MIC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;      // capture the input transfer
        logic exec;      // accumulate, start/stop, first gain product
        logic prep;      // set up division, loudness product, playout start
        logic div_step;  // one quotient bit
        logic commit;    // advance playout clock, close frame
        logic hold;      // extend gate hold time
        logic mic;       // apply gate to mic sample
        logic finish;    // load output register
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  frame_end;  // last-in-frame item while playing
        logic  div_last;   // final divider step
    } status_t;

    // a is after b on the wrapping millisecond clock
    function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI)
            r = SAMPLE_MAX;
        else if (v < SAT_LO)
            r = SAMPLE_MIN;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

@@ hdl/echo_gate_with_playout_clock.sv @@
// ----------------------------------------------------------------------------
// echo_gate_with_playout_clock
// Items pass load and exec; start, stop and plain far-end items then go to the
// output register, mic items pass the gate step first, and a far-end frame end
// passes prep, the serial divider (BYTES_W = clog2(MAX_FRAME_SAMPLES + 1) + 1
// quotient bits), commit and hold. One item at a time; input taken while a result waits.
// Reset clears clocks, accumulators, playback flag and registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_gate_with_playout_clock #(
    parameter int MAX_FRAME_SAMPLES = egpc_pkg::DEFAULT_MAX_FRAME_SAMPLES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [egpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [egpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic signed [15:0]                sample_in,
    input  logic                              last_in_frame,
    input  logic [31:0]                       time_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                sample_out,
    output logic                              far_end_active,
    output logic                              frame_taken
);
    import egpc_pkg::*;

    cmd_t    cmd;
    status_t status;

    egpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    egpc_datapath #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .sample_in      (sample_in),
        .last_in_frame  (last_in_frame),
        .time_ms        (time_ms),
        .sample_out     (sample_out),
        .far_end_active (far_end_active),
        .frame_taken    (frame_taken)
    );

endmodule

@@ hdl/egpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// egpc_ctrl
// Sequencer: steps each item through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module egpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  egpc_pkg::status_t  status,
    output egpc_pkg::cmd_t     cmd
);
    import egpc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.kind == KIND_FAR && status.frame_end)
                    state_next = ST_PREP;
                else if (status.kind == KIND_MIC)
                    state_next = ST_MIC;
                else
                    state_next = ST_FIN;
            end
            ST_PREP:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT: state_next = ST_HOLD;
            ST_HOLD:   state_next = ST_FIN;
            ST_MIC:    state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.prep     = (state_reg == ST_PREP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.commit   = (state_reg == ST_COMMIT);
        cmd.hold     = (state_reg == ST_HOLD);
        cmd.mic      = (state_reg == ST_MIC);
        cmd.finish   = (state_reg == ST_FIN) && out_free;
    end

    // hold the result until the downstream transfer, then drop valid
    assign out_valid_next = (out_valid_reg && out_stall) || cmd.finish;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ hdl/egpc_datapath.sv @@
// ----------------------------------------------------------------------------
// egpc_datapath
// Config registers, frame accumulators, playout clock, serial divider and
// mic gain / gate arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module egpc_datapath #(
    parameter int MAX_FRAME_SAMPLES = egpc_pkg::DEFAULT_MAX_FRAME_SAMPLES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  egpc_pkg::cmd_t                        cmd,
    output egpc_pkg::status_t                     status,
    input  logic                                  cfg_we,
    input  logic [egpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [egpc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [1:0]                            kind,
    input  logic signed [15:0]                    sample_in,
    input  logic                                  last_in_frame,
    input  logic [31:0]                           time_ms,
    output logic signed [15:0]                    sample_out,
    output logic                                  far_end_active,
    output logic                                  frame_taken
);
    import egpc_pkg::*;

    localparam int FS_W    = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int ABS_W   = 16 + FS_W;
    localparam int BYTES_W = FS_W + 1;
    localparam int CNT_W   = $clog2(BYTES_W);
    localparam int PROD_W  = 17 + FS_W;

    // configuration
    logic [14:0]        gain_reg;
    logic signed [9:0]  gf_reg;
    logic [15:0]        thr_reg;
    logic [15:0]        hang_reg;
    logic [7:0]         bpm_reg;

    // control state
    logic [31:0]        playout_end_reg;
    logic [31:0]        hold_until_reg;
    logic               playback_on_reg;
    logic [ABS_W-1:0]   abs_sum_reg;
    logic [FS_W-1:0]    fs_reg;

    // item and working registers
    kind_t              kind_reg;
    logic signed [15:0] s_reg;
    logic               last_reg;
    logic [31:0]        t_reg;
    logic [31:0]        start_reg;
    logic [PROD_W-1:0]  thr_prod_reg;
    logic [7:0]         rem_reg;
    logic [BYTES_W-1:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               loud_reg;
    logic               taken_reg;
    logic signed [15:0] v1_reg;
    logic signed [15:0] res_reg;
    logic signed [15:0] sample_out_reg;
    logic               fea_reg;
    logic               taken_out_reg;

    logic               gate_on;
    logic               gate_active;
    logic [15:0]        abs_s;
    logic [16:0]        thr_p1;
    logic [8:0]         trial;
    logic               trial_ge;
    logic [BYTES_W-1:0] fms;
    logic [31:0]        hold_cand;
    logic signed [31:0] mic_prod;
    logic signed [31:0] mic_shift;
    logic signed [31:0] gate_prod;
    logic signed [31:0] gate_shift;

    assign gate_on     = !gf_reg[9];
    assign gate_active = gate_on && is_after(hold_until_reg, t_reg);
    assign abs_s       = s_reg[15] ? (~s_reg + 16'd1) : s_reg;
    assign thr_p1      = {1'b0, thr_reg} + 17'd1;
    assign trial       = {rem_reg, q_reg[BYTES_W-1]};
    assign trial_ge    = (trial >= {1'b0, bpm_reg});
    assign fms         = (bpm_reg == 8'd0) ? '0 : q_reg;
    assign hold_cand   = playout_end_reg + {16'd0, hang_reg};
    assign mic_prod    = s_reg * $signed({1'b0, gain_reg});
    assign mic_shift   = mic_prod >>> 8;
    assign gate_prod   = v1_reg * gf_reg;
    assign gate_shift  = gate_prod >>> 8;

    assign status.kind      = kind_reg;
    assign status.frame_end = playback_on_reg && last_reg;
    assign status.div_last  = (cnt_reg == CNT_W'(BYTES_W - 1));

    // configuration and clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= RST_MAKEUP_GAIN;
            gf_reg          <= RST_GATE_FACTOR;
            thr_reg         <= RST_LOUD_THRESHOLD;
            hang_reg        <= RST_HANGOVER_MS;
            bpm_reg         <= RST_BYTES_PER_MS;
            playout_end_reg <= '0;
            hold_until_reg  <= '0;
            playback_on_reg <= 1'b0;
            abs_sum_reg     <= '0;
            fs_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAKEUP_GAIN:    gain_reg <= cfg_data[14:0];
                    CFG_GATE_FACTOR:    gf_reg   <= cfg_data[9:0];
                    CFG_LOUD_THRESHOLD: thr_reg  <= cfg_data;
                    CFG_HANGOVER_MS:    hang_reg <= cfg_data;
                    CFG_BYTES_PER_MS:   bpm_reg  <= cfg_data[7:0];
                    default:            ;
                endcase
            end

            if (cmd.exec)
            begin
                if (kind_reg == KIND_FAR)
                begin
                    if (playback_on_reg && fs_reg < FS_W'(MAX_FRAME_SAMPLES))
                    begin
                        abs_sum_reg <= abs_sum_reg + ABS_W'(abs_s);
                        fs_reg      <= fs_reg + FS_W'(1);
                    end
                end
                else if ((kind_reg == KIND_START && !playback_on_reg) ||
                         (kind_reg == KIND_STOP && playback_on_reg))
                begin
                    playback_on_reg <= (kind_reg == KIND_START);
                    playout_end_reg <= '0;
                    hold_until_reg  <= '0;
                    abs_sum_reg     <= '0;
                    fs_reg          <= '0;
                end
            end

            if (cmd.commit)
            begin
                playout_end_reg <= start_reg + 32'(fms);
                abs_sum_reg     <= '0;
                fs_reg          <= '0;
            end

            if (cmd.hold && gate_on && loud_reg && is_after(hold_cand, hold_until_reg))
                hold_until_reg <= hold_cand;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(kind);
            s_reg     <= sample_in;
            last_reg  <= last_in_frame;
            t_reg     <= time_ms;
            taken_reg <= 1'b0;
            res_reg   <= '0;
        end

        if (cmd.exec)
            v1_reg <= sat16(mic_shift);

        if (cmd.prep)
        begin
            start_reg    <= is_after(playout_end_reg, t_reg) ? playout_end_reg : t_reg;
            thr_prod_reg <= PROD_W'(thr_p1) * PROD_W'(fs_reg);
            q_reg        <= {fs_reg, 1'b0};
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end

        // restoring divide, one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= 8'(trial - {1'b0, bpm_reg});
                q_reg   <= {q_reg[BYTES_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[7:0];
                q_reg   <= {q_reg[BYTES_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        // floor(sum / n) > thr  <=>  sum >= (thr + 1) * n
        if (cmd.commit)
        begin
            loud_reg  <= (fs_reg != '0) && (PROD_W'(abs_sum_reg) >= thr_prod_reg);
            taken_reg <= 1'b1;
        end

        if (cmd.mic)
        begin
            if (!gate_active)
                res_reg <= v1_reg;
            else if (gf_reg == 10'sd0)
                res_reg <= '0;
            else
                res_reg <= sat16(gate_shift);
        end

        if (cmd.finish)
        begin
            sample_out_reg <= res_reg;
            fea_reg        <= gate_active;
            taken_out_reg  <= taken_reg;
        end
    end

    assign sample_out     = sample_out_reg;
    assign far_end_active = fea_reg;
    assign frame_taken    = taken_out_reg;

endmodule
